[hw/rtl/lru_segment_cache_manager_defines.svh]
`ifndef LRU_SEGMENT_CACHE_MANAGER_DEFINES_SVH
`define LRU_SEGMENT_CACHE_MANAGER_DEFINES_SVH

// same-cycle implication, clocked on clk, off during reset
`define LSCM_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define LSCM_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[hw/rtl/lscm_pkg.sv]
`default_nettype none
package lscm_pkg;

    localparam int LSCM_OFF_W     = 48;
    localparam int LSCM_SEGB_W    = 24;
    localparam int LSCM_IDX_W     = 12;
    localparam int LSCM_SLCFG_W   = 5;
    localparam int LSCM_CFGIDX_W  = 2;
    localparam int LSCM_SLOTS     = 16;
    localparam int LSCM_MAX_SEGMENTS = 4096;

    localparam logic [LSCM_OFF_W-1:0]   LSCM_TOTAL_RST = 48'd4194304;
    localparam logic [LSCM_SEGB_W-1:0]  LSCM_SEGB_RST  = 24'd65536;
    localparam logic [LSCM_SLCFG_W-1:0] LSCM_SLCFG_RST = 5'd16;

    localparam logic [LSCM_CFGIDX_W-1:0] LSCM_CFG_TOTAL = 2'd0;
    localparam logic [LSCM_CFGIDX_W-1:0] LSCM_CFG_SEGB  = 2'd1;
    localparam logic [LSCM_CFGIDX_W-1:0] LSCM_CFG_SLOTS = 2'd2;

    localparam logic [1:0] LSCM_REQ_READ  = 2'd0;
    localparam logic [1:0] LSCM_REQ_WRITE = 2'd1;
    localparam logic [1:0] LSCM_REQ_INFO  = 2'd2;
    localparam logic [1:0] LSCM_REQ_QUERY = 2'd3;

    localparam logic [1:0] LSCM_ST_OK         = 2'd0;
    localparam logic [1:0] LSCM_ST_NOT_CACHED = 2'd1;
    localparam logic [1:0] LSCM_ST_RANGE      = 2'd2;

    typedef struct packed {
        logic load;
        logic div_start;
        logic div_sel;
        logic cap_a;
        logic cap_b;
        logic scan_en;
        logic upd;
        logic out_load;
    } lscm_cmd_t;

    typedef struct packed {
        logic [1:0] req_type;
        logic       oor;
        logic       div_done;
        logic       scan_last;
        logic       taken_zero;
    } lscm_sts_t;

    typedef struct packed {
        logic [1:0]             status;
        logic                   present;
        logic [3:0]             slot;
        logic [LSCM_IDX_W-1:0]  seg_index_out;
        logic [LSCM_OFF_W-1:0]  seg_base;
        logic [LSCM_SEGB_W-1:0] seg_size_out;
        logic [LSCM_SEGB_W-1:0] offset_in_seg;
        logic [LSCM_SEGB_W-1:0] length_out;
        logic                   evicted;
        logic [LSCM_IDX_W-1:0]  evicted_index;
    } lscm_res_t;

endpackage
`default_nettype wire

[hw/rtl/lscm_if.sv]
`default_nettype none
interface lscm_req_if;
    logic                                valid;
    logic                                ready;
    logic [1:0]                          req_type;
    logic [lscm_pkg::LSCM_OFF_W-1:0]     byte_offset_in;
    logic [lscm_pkg::LSCM_IDX_W-1:0]     seg_index_in;
    logic [lscm_pkg::LSCM_SEGB_W-1:0]    seg_size_in;
    logic [lscm_pkg::LSCM_SEGB_W-1:0]    read_len;
    modport source (output valid, req_type, byte_offset_in, seg_index_in, seg_size_in,
                    read_len, input ready);
    modport sink (input valid, req_type, byte_offset_in, seg_index_in, seg_size_in,
                  read_len, output ready);
endinterface

interface lscm_rsp_if;
    logic                                valid;
    logic                                ready;
    logic [1:0]                          status;
    logic                                present;
    logic [3:0]                          slot;
    logic [lscm_pkg::LSCM_IDX_W-1:0]     seg_index_out;
    logic [lscm_pkg::LSCM_OFF_W-1:0]     seg_base;
    logic [lscm_pkg::LSCM_SEGB_W-1:0]    seg_size_out;
    logic [lscm_pkg::LSCM_SEGB_W-1:0]    offset_in_seg;
    logic [lscm_pkg::LSCM_SEGB_W-1:0]    length_out;
    logic                                evicted;
    logic [lscm_pkg::LSCM_IDX_W-1:0]     evicted_index;
    modport source (output valid, status, present, slot, seg_index_out, seg_base,
                    seg_size_out, offset_in_seg, length_out, evicted, evicted_index,
                    input ready);
    modport sink (input valid, status, present, slot, seg_index_out, seg_base,
                  seg_size_out, offset_in_seg, length_out, evicted, evicted_index,
                  output ready);
endinterface

interface lscm_cfg_if;
    logic                                valid;
    logic                                ready;
    logic [lscm_pkg::LSCM_CFGIDX_W-1:0]  index;
    logic [lscm_pkg::LSCM_OFF_W-1:0]     data;
    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface
`default_nettype wire

[hw/rtl/lscm_div.sv]
`default_nettype none
module lscm_div (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               start,
    input  wire logic [lscm_pkg::LSCM_OFF_W-1:0]    dividend,
    input  wire logic [lscm_pkg::LSCM_SEGB_W-1:0]   divisor,
    output logic      [lscm_pkg::LSCM_OFF_W-1:0]    quot,
    output logic      [lscm_pkg::LSCM_SEGB_W-1:0]   rem,
    output logic                                    done
);
    import lscm_pkg::*;

    localparam int NW = $clog2(LSCM_OFF_W);

    logic [LSCM_OFF_W-1:0]  q_reg;
    logic [LSCM_SEGB_W-1:0] r_reg;
    logic [LSCM_SEGB_W-1:0] d_reg;
    logic [NW-1:0]          cnt_reg;
    logic                   busy_reg;
    logic                   done_reg;
    logic [LSCM_SEGB_W:0]   trial;
    logic [LSCM_SEGB_W:0]   diff;
    logic                   ge;

    // restoring, one quotient bit a cycle
    assign trial = {r_reg, q_reg[LSCM_OFF_W-1]};
    assign diff  = trial - {1'b0, d_reg};
    assign ge    = trial >= {1'b0, d_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else if (start)
        begin
            cnt_reg  <= '0;
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg + NW'(1);
            if (cnt_reg == NW'(LSCM_OFF_W - 1))
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
        else
        begin
            done_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            q_reg <= dividend;
            r_reg <= '0;
            d_reg <= divisor;
        end
        else if (busy_reg)
        begin
            q_reg <= {q_reg[LSCM_OFF_W-2:0], ge};
            r_reg <= ge ? diff[LSCM_SEGB_W-1:0] : trial[LSCM_SEGB_W-1:0];
        end
    end

    assign quot = q_reg;
    assign rem  = r_reg;
    assign done = done_reg;
endmodule
`default_nettype wire

[hw/rtl/lscm_dp.sv]
`default_nettype none
module lscm_dp #(
    parameter int SLOTS = lscm_pkg::LSCM_SLOTS
) (
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,
    input  wire lscm_pkg::lscm_cmd_t                  cmd,
    output lscm_pkg::lscm_sts_t                       sts,
    input  wire logic [1:0]                           req_type,
    input  wire logic [lscm_pkg::LSCM_OFF_W-1:0]      byte_offset_in,
    input  wire logic [lscm_pkg::LSCM_IDX_W-1:0]      seg_index_in,
    input  wire logic [lscm_pkg::LSCM_SEGB_W-1:0]     seg_size_in,
    input  wire logic [lscm_pkg::LSCM_SEGB_W-1:0]     read_len,
    input  wire logic                                 cfg_we,
    input  wire logic [lscm_pkg::LSCM_CFGIDX_W-1:0]   cfg_index,
    input  wire logic [lscm_pkg::LSCM_OFF_W-1:0]      cfg_data,
    output lscm_pkg::lscm_res_t                       res
);
    import lscm_pkg::*;

    localparam int IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int CW = $clog2(SLOTS + 1);
    localparam int KW = (CW > LSCM_SLCFG_W) ? CW : LSCM_SLCFG_W;
    localparam int PW = LSCM_IDX_W + LSCM_SEGB_W;

    logic [LSCM_OFF_W-1:0]   total_reg;
    logic [LSCM_SEGB_W-1:0]  segb_reg;
    logic [LSCM_SLCFG_W-1:0] slcfg_reg;

    logic [1:0]              req_reg;
    logic [LSCM_OFF_W-1:0]   off_reg;
    logic [LSCM_IDX_W-1:0]   sidx_reg;
    logic [LSCM_SEGB_W-1:0]  size_reg;
    logic [LSCM_SEGB_W-1:0]  rlen_reg;

    logic [LSCM_OFF_W-1:0]   q_a_reg;
    logic [LSCM_SEGB_W-1:0]  r_a_reg;
    logic [LSCM_OFF_W-1:0]   q_b_reg;
    logic [LSCM_SEGB_W-1:0]  r_b_reg;

    logic [LSCM_IDX_W-1:0]   seg_mem [SLOTS];
    logic [LSCM_SEGB_W-1:0]  len_mem [SLOTS];
    logic [IW-1:0]           rank_reg [SLOTS];
    logic [IW-1:0]           rank_next [SLOTS];
    logic [CW-1:0]           taken_reg;

    logic [IW-1:0]           ptr_reg;
    logic                    hit_reg;
    logic [IW-1:0]           hit_slot_reg;
    logic [LSCM_SEGB_W-1:0]  hit_len_reg;
    logic [IW-1:0]           hit_rank_reg;
    logic [IW-1:0]           lru_slot_reg;
    logic [IW-1:0]           lru_rank_reg;
    logic [LSCM_IDX_W-1:0]   lru_seg_reg;

    logic [IW-1:0]           res_slot_reg;
    logic [IW-1:0]           res_slot_next;
    logic [LSCM_SEGB_W-1:0]  res_len_reg;
    logic [LSCM_SEGB_W-1:0]  res_len_next;
    logic                    evict_reg;
    logic                    evict_next;
    logic [LSCM_IDX_W-1:0]   ev_idx_reg;

    logic [LSCM_SEGB_W-1:0]  sb;
    logic [KW-1:0]           slcfg_ext;
    logic [CW-1:0]           cap;
    logic                    full;
    logic [LSCM_OFF_W-1:0]   div_dividend;
    logic [LSCM_OFF_W-1:0]   div_quot;
    logic [LSCM_SEGB_W-1:0]  div_rem;
    logic                    div_done;
    logic                    key_valid;
    logic [LSCM_IDX_W-1:0]   key_idx;
    logic                    scan_last;
    logic                    wr_ok;

    logic                    wr_en;
    logic [IW-1:0]           wr_addr;
    logic                    touch_en;
    logic [IW-1:0]           touch_s;
    logic [CW-1:0]           touch_old;
    logic                    taken_inc;

    logic [LSCM_SEGB_W-1:0]  avail;
    logic [LSCM_OFF_W-1:0]   base_off;
    logic [PW-1:0]           prod;
    logic                    query_in;

    // segment size 0 counts as 1
    assign sb = (segb_reg == '0) ? LSCM_SEGB_W'(1) : segb_reg;

    assign slcfg_ext = KW'(slcfg_reg);
    always_comb
    begin
        if (slcfg_reg == '0)
            cap = CW'(1);
        else if (slcfg_ext > KW'(SLOTS))
            cap = CW'(SLOTS);
        else
            cap = CW'(slcfg_ext);
    end
    assign full  = taken_reg >= cap;
    assign wr_ok = {1'b0, sidx_reg} < (LSCM_IDX_W + 1)'(LSCM_MAX_SEGMENTS);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            total_reg <= LSCM_TOTAL_RST;
            segb_reg  <= LSCM_SEGB_RST;
            slcfg_reg <= LSCM_SLCFG_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                LSCM_CFG_TOTAL: total_reg <= cfg_data;
                LSCM_CFG_SEGB:  segb_reg  <= cfg_data[LSCM_SEGB_W-1:0];
                LSCM_CFG_SLOTS: slcfg_reg <= cfg_data[LSCM_SLCFG_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            req_reg  <= req_type;
            off_reg  <= byte_offset_in;
            sidx_reg <= seg_index_in;
            size_reg <= seg_size_in;
            rlen_reg <= read_len;
        end
        if (cmd.cap_a)
        begin
            q_a_reg <= div_quot;
            r_a_reg <= div_rem;
        end
        if (cmd.cap_b)
        begin
            q_b_reg <= div_quot;
            r_b_reg <= div_rem;
        end
    end

    assign div_dividend = cmd.div_sel ? (total_reg - LSCM_OFF_W'(1)) : off_reg;

    lscm_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.div_start),
        .dividend (div_dividend),
        .divisor  (sb),
        .quot     (div_quot),
        .rem      (div_rem),
        .done     (div_done)
    );

    always_comb
    begin
        if (req_reg == LSCM_REQ_READ || req_reg == LSCM_REQ_INFO)
        begin
            key_valid = q_a_reg < LSCM_OFF_W'(LSCM_MAX_SEGMENTS);
            key_idx   = q_a_reg[LSCM_IDX_W-1:0];
        end
        else
        begin
            key_valid = 1'b1;
            key_idx   = sidx_reg;
        end
    end

    assign scan_last = (CW'(ptr_reg) + CW'(1)) == taken_reg;

    // tag scan, one slot a cycle; also tracks the oldest slot
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ptr_reg <= '0;
            hit_reg <= 1'b0;
        end
        else if (cmd.load)
        begin
            ptr_reg <= '0;
            hit_reg <= 1'b0;
        end
        else if (cmd.scan_en)
        begin
            if (key_valid && seg_mem[ptr_reg] == key_idx && !hit_reg)
                hit_reg <= 1'b1;
            if (!scan_last)
                ptr_reg <= ptr_reg + IW'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.scan_en)
        begin
            if (key_valid && seg_mem[ptr_reg] == key_idx && !hit_reg)
            begin
                hit_slot_reg <= ptr_reg;
                hit_len_reg  <= len_mem[ptr_reg];
                hit_rank_reg <= rank_reg[ptr_reg];
            end
            if (ptr_reg == '0 || rank_reg[ptr_reg] >= lru_rank_reg)
            begin
                lru_slot_reg <= ptr_reg;
                lru_rank_reg <= rank_reg[ptr_reg];
                lru_seg_reg  <= seg_mem[ptr_reg];
            end
        end
    end

    always_comb
    begin
        wr_en         = 1'b0;
        wr_addr       = lru_slot_reg;
        touch_en      = 1'b0;
        touch_s       = hit_slot_reg;
        touch_old     = CW'(hit_rank_reg);
        taken_inc     = 1'b0;
        res_slot_next = hit_slot_reg;
        res_len_next  = hit_len_reg;
        evict_next    = 1'b0;
        case (req_reg)
            LSCM_REQ_READ:
            begin
                touch_en = hit_reg;
            end
            LSCM_REQ_WRITE:
            begin
                if (wr_ok)
                begin
                    touch_en = 1'b1;
                    if (!hit_reg)
                    begin
                        wr_en        = 1'b1;
                        res_len_next = size_reg;
                        if (full)
                        begin
                            touch_s       = lru_slot_reg;
                            touch_old     = CW'(lru_rank_reg);
                            res_slot_next = lru_slot_reg;
                            evict_next    = 1'b1;
                        end
                        else
                        begin
                            wr_addr       = taken_reg[IW-1:0];
                            touch_s       = taken_reg[IW-1:0];
                            touch_old     = taken_reg + CW'(1);
                            res_slot_next = taken_reg[IW-1:0];
                            taken_inc     = 1'b1;
                        end
                    end
                end
            end
            default: ;
        endcase
    end

    always_comb
    begin
        for (int k = 0; k < SLOTS; k++)
        begin
            rank_next[k] = rank_reg[k];
            if (cmd.upd && touch_en)
            begin
                if (IW'(k) == touch_s)
                    rank_next[k] = '0;
                else if (CW'(k) < taken_reg && CW'(rank_reg[k]) < touch_old)
                    rank_next[k] = rank_reg[k] + IW'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        for (int k = 0; k < SLOTS; k++)
            rank_reg[k] <= rank_next[k];
        if (cmd.upd && wr_en)
        begin
            seg_mem[wr_addr] <= sidx_reg;
            len_mem[wr_addr] <= size_reg;
        end
        if (cmd.upd)
        begin
            res_slot_reg <= res_slot_next;
            res_len_reg  <= res_len_next;
            evict_reg    <= evict_next;
            ev_idx_reg   <= lru_seg_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            taken_reg <= '0;
        else if (cmd.upd && taken_inc)
            taken_reg <= taken_reg + CW'(1);
    end

    assign sts.req_type   = req_reg;
    assign sts.oor        = off_reg >= total_reg;
    assign sts.div_done   = div_done;
    assign sts.scan_last  = scan_last;
    assign sts.taken_zero = taken_reg == '0;

    assign avail    = (r_a_reg < hit_len_reg) ? (hit_len_reg - r_a_reg) : '0;
    assign base_off = off_reg - LSCM_OFF_W'(r_a_reg);
    assign prod     = PW'(sidx_reg) * PW'(sb);
    assign query_in = (total_reg != '0) && (LSCM_OFF_W'(sidx_reg) <= q_b_reg);

    always_comb
    begin
        res = '0;
        case (req_reg)
            LSCM_REQ_READ:
            begin
                res.seg_index_out = q_a_reg[LSCM_IDX_W-1:0];
                if (hit_reg)
                begin
                    res.present       = 1'b1;
                    res.slot          = 4'(hit_slot_reg);
                    res.seg_base      = base_off;
                    res.seg_size_out  = hit_len_reg;
                    res.offset_in_seg = r_a_reg;
                    res.length_out    = (rlen_reg < avail) ? rlen_reg : avail;
                end
                else
                begin
                    res.status = LSCM_ST_NOT_CACHED;
                end
            end
            LSCM_REQ_WRITE:
            begin
                if (!wr_ok)
                begin
                    res.status = LSCM_ST_RANGE;
                end
                else
                begin
                    res.present       = 1'b1;
                    res.slot          = 4'(res_slot_reg);
                    res.seg_index_out = sidx_reg;
                    res.seg_base      = LSCM_OFF_W'(prod);
                    res.seg_size_out  = res_len_reg;
                    res.length_out    = res_len_reg;
                    res.evicted       = evict_reg;
                    res.evicted_index = evict_reg ? ev_idx_reg : '0;
                end
            end
            LSCM_REQ_INFO:
            begin
                if (sts.oor)
                begin
                    res.status = LSCM_ST_RANGE;
                end
                else
                begin
                    res.seg_index_out = q_a_reg[LSCM_IDX_W-1:0];
                    res.seg_base      = base_off;
                    if (hit_reg)
                    begin
                        res.present      = 1'b1;
                        res.slot         = 4'(hit_slot_reg);
                        res.seg_size_out = hit_len_reg;
                    end
                    else if (q_a_reg == q_b_reg)
                        res.seg_size_out = r_b_reg + LSCM_SEGB_W'(1);
                    else
                        res.seg_size_out = sb;
                end
            end
            default:
            begin
                res.seg_index_out = sidx_reg;
                if (query_in && hit_reg)
                begin
                    res.present = 1'b1;
                    res.slot    = 4'(hit_slot_reg);
                end
            end
        endcase
    end
endmodule
`default_nettype wire

[hw/rtl/lscm_ctrl.sv]
`default_nettype none
module lscm_ctrl (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 in_fire,
    input  wire logic                 out_free,
    input  wire lscm_pkg::lscm_sts_t  sts,
    output logic                      in_ready,
    output lscm_pkg::lscm_cmd_t       cmd
);
    import lscm_pkg::*;

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_DISP = 3'd1;
    localparam logic [2:0] ST_DIVA = 3'd2;
    localparam logic [2:0] ST_DIVB = 3'd3;
    localparam logic [2:0] ST_SCAN = 3'd4;
    localparam logic [2:0] ST_UPD  = 3'd5;
    localparam logic [2:0] ST_OUT  = 3'd6;

    logic [2:0] state_reg;
    logic [2:0] state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

    assign in_ready = state_reg == ST_IDLE;

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_fire)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_DISP;
                end
            end
            ST_DISP:
            begin
                case (sts.req_type)
                    LSCM_REQ_READ:
                    begin
                        cmd.div_start = 1'b1;
                        state_next    = ST_DIVA;
                    end
                    LSCM_REQ_WRITE:
                    begin
                        state_next = ST_SCAN;
                    end
                    LSCM_REQ_INFO:
                    begin
                        if (sts.oor)
                            state_next = ST_OUT;
                        else
                        begin
                            cmd.div_start = 1'b1;
                            state_next    = ST_DIVA;
                        end
                    end
                    default:
                    begin
                        cmd.div_start = 1'b1;
                        cmd.div_sel   = 1'b1;
                        state_next    = ST_DIVB;
                    end
                endcase
            end
            ST_DIVA:
            begin
                if (sts.div_done)
                begin
                    cmd.cap_a = 1'b1;
                    if (sts.req_type == LSCM_REQ_INFO)
                    begin
                        cmd.div_start = 1'b1;
                        cmd.div_sel   = 1'b1;
                        state_next    = ST_DIVB;
                    end
                    else
                        state_next = ST_SCAN;
                end
            end
            ST_DIVB:
            begin
                if (sts.div_done)
                begin
                    cmd.cap_b  = 1'b1;
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (sts.taken_zero)
                    state_next = ST_UPD;
                else
                begin
                    cmd.scan_en = 1'b1;
                    if (sts.scan_last)
                        state_next = ST_UPD;
                end
            end
            ST_UPD:
            begin
                cmd.upd    = 1'b1;
                state_next = ST_OUT;
            end
            ST_OUT:
            begin
                if (out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end
endmodule
`default_nettype wire

[hw/rtl/lru_segment_cache_manager.sv]
// channel | dir | transfer when         | payload
// req     | in  | req.valid & req.ready | request type, offset, index, size, length
// rsp     | out | rsp.valid & rsp.ready | one result per request
// cfg     | in  | cfg.valid & cfg.ready | register index, write data
//
// Read and query run the 48-step divider once, info twice, write not at all;
// then the one-slot-a-cycle tag scan over the taken slots, the update state and
// the output state follow. Info with an out-of-range offset goes straight to output.
// Next request is taken once the previous result sits in the output register.
// Reset clears the slot count and controller; slot contents are written before use.
// Output register holds a result under back-pressure; the controller waits in its last state.
`default_nettype none
`include "lru_segment_cache_manager_defines.svh"
module lru_segment_cache_manager #(
    parameter int SLOTS = lscm_pkg::LSCM_SLOTS
) (
    input  wire logic  clk,
    input  wire logic  rst_n,
    lscm_req_if.sink   req,
    lscm_rsp_if.source rsp,
    lscm_cfg_if.sink   cfg
);
    import lscm_pkg::*;

    lscm_cmd_t cmd;
    lscm_sts_t sts;
    lscm_res_t res;
    lscm_res_t res_reg;
    logic      rsp_valid_reg;
    logic      out_free;
    logic      in_ready;

    assign out_free  = !rsp_valid_reg || rsp.ready;
    assign req.ready = in_ready;
    assign cfg.ready = 1'b1;

    lscm_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_fire  (req.valid && in_ready),
        .out_free (out_free),
        .sts      (sts),
        .in_ready (in_ready),
        .cmd      (cmd)
    );

    lscm_dp #(
        .SLOTS (SLOTS)
    ) u_dp (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .sts            (sts),
        .req_type       (req.req_type),
        .byte_offset_in (req.byte_offset_in),
        .seg_index_in   (req.seg_index_in),
        .seg_size_in    (req.seg_size_in),
        .read_len       (req.read_len),
        .cfg_we         (cfg.valid),
        .cfg_index      (cfg.index),
        .cfg_data       (cfg.data),
        .res            (res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            rsp_valid_reg <= 1'b0;
        else if (cmd.out_load)
            rsp_valid_reg <= 1'b1;
        else if (rsp.ready)
            rsp_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
            res_reg <= res;
    end

    assign rsp.valid         = rsp_valid_reg;
    assign rsp.status        = res_reg.status;
    assign rsp.present       = res_reg.present;
    assign rsp.slot          = res_reg.slot;
    assign rsp.seg_index_out = res_reg.seg_index_out;
    assign rsp.seg_base      = res_reg.seg_base;
    assign rsp.seg_size_out  = res_reg.seg_size_out;
    assign rsp.offset_in_seg = res_reg.offset_in_seg;
    assign rsp.length_out    = res_reg.length_out;
    assign rsp.evicted       = res_reg.evicted;
    assign rsp.evicted_index = res_reg.evicted_index;

    `LSCM_ASSERT_IMP(a_out_load_free, cmd.out_load, !rsp_valid_reg || rsp.ready, "result overwrite")
    `LSCM_ASSERT_NXT(a_busy_after_transfer, req.valid && req.ready, !req.ready, "request overlap")
    `LSCM_ASSERT_IMP(a_load_on_transfer, cmd.load, req.valid && req.ready, "load without transfer")
endmodule
`default_nettype wire

[bench/tb_top.sv]
`timescale 1ns / 100ps
`default_nettype none
module tb_top;
    import lscm_pkg::*;

    localparam int CYCLE_LIMIT = 2000000;
    localparam int SETTLE      = 150;

    typedef struct packed {
        logic [1:0]             kind;
        logic [LSCM_OFF_W-1:0]  offs;
        logic [LSCM_IDX_W-1:0]  idx;
        logic [LSCM_SEGB_W-1:0] size;
        logic [LSCM_SEGB_W-1:0] rlen;
    } request_t;

    logic clk;
    logic rst_n;

    lscm_req_if req();
    lscm_rsp_if rsp();
    lscm_cfg_if cfg();

    lru_segment_cache_manager dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req),
        .rsp   (rsp),
        .cfg   (cfg)
    );

    // predictor state
    logic [LSCM_OFF_W-1:0]   total_cfg;
    logic [LSCM_SEGB_W-1:0]  segb_cfg;
    logic [LSCM_SLCFG_W-1:0] slots_cfg;
    bit                      seg_cached [LSCM_MAX_SEGMENTS];
    logic [LSCM_IDX_W-1:0]   slot_seg [LSCM_SLOTS];
    logic [LSCM_SEGB_W-1:0]  slot_size [LSCM_SLOTS];
    int unsigned             slot_rank [LSCM_SLOTS];
    int unsigned             taken;

    lscm_res_t expected_results[$];
    int  cycles;
    int  mismatches;
    int  stray_results;
    int  results_checked;
    int  requests_sent;
    int  evictions_seen;
    int  cfg_writes;
    int  burst_left;
    int  ready_pct;
    int  ready_span;
    int  kind_count [4];

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    function automatic longint unsigned eff_segb();
        return (segb_cfg == 0) ? 64'd1 : 64'(segb_cfg);
    endfunction

    function automatic int unsigned capacity();
        if (slots_cfg == 0)
            return 1;
        if (slots_cfg > LSCM_SLOTS)
            return LSCM_SLOTS;
        return slots_cfg;
    endfunction

    function automatic longint unsigned seg_count();
        if (total_cfg == 0)
            return 0;
        return 1 + (64'(total_cfg) - 1) / eff_segb();
    endfunction

    function automatic int lookup_slot(longint unsigned i);
        if (i >= LSCM_MAX_SEGMENTS || !seg_cached[i])
            return -1;
        for (int k = 0; k < taken; k++)
            if (slot_seg[k] == i)
                return k;
        return -1;
    endfunction

    function automatic void make_recent(int s, int unsigned old_rank);
        for (int k = 0; k < taken; k++)
            if (k != s && slot_rank[k] < old_rank)
                slot_rank[k]++;
        slot_rank[s] = 0;
    endfunction

    function automatic lscm_res_t cache_predict(request_t r);
        lscm_res_t o;
        longint unsigned sb;
        longint unsigned q;
        longint unsigned rel;
        longint unsigned sz;
        longint unsigned avail;
        longint unsigned rem;
        int s;
        int lru;
        o = '0;
        sb = eff_segb();
        case (r.kind)
            LSCM_REQ_READ:
            begin
                q = 64'(r.offs) / sb;
                rel = 64'(r.offs) - q * sb;
                o.seg_index_out = q[LSCM_IDX_W-1:0];
                s = lookup_slot(q);
                if (s < 0)
                    o.status = LSCM_ST_NOT_CACHED;
                else
                begin
                    sz = slot_size[s];
                    avail = (rel < sz) ? sz - rel : 0;
                    o.present = 1'b1;
                    o.slot = s[3:0];
                    o.seg_base = 48'(q * sb);
                    o.seg_size_out = sz[LSCM_SEGB_W-1:0];
                    o.offset_in_seg = rel[LSCM_SEGB_W-1:0];
                    o.length_out = (64'(r.rlen) < avail) ? r.rlen : avail[LSCM_SEGB_W-1:0];
                    make_recent(s, slot_rank[s]);
                end
            end
            LSCM_REQ_WRITE:
            begin
                s = lookup_slot(r.idx);
                if (s < 0)
                begin
                    if (taken >= capacity() && taken > 0)
                    begin
                        lru = 0;
                        for (int k = 0; k < taken; k++)
                            if (slot_rank[k] >= slot_rank[lru])
                                lru = k;
                        seg_cached[slot_seg[lru]] = 1'b0;
                        o.evicted = 1'b1;
                        o.evicted_index = slot_seg[lru];
                        s = lru;
                        slot_seg[s] = r.idx;
                        slot_size[s] = r.size;
                        seg_cached[r.idx] = 1'b1;
                        make_recent(s, slot_rank[s]);
                    end
                    else
                    begin
                        s = taken;
                        taken++;
                        slot_seg[s] = r.idx;
                        slot_size[s] = r.size;
                        seg_cached[r.idx] = 1'b1;
                        slot_rank[s] = taken;
                        make_recent(s, taken);
                    end
                end
                else
                    make_recent(s, slot_rank[s]);
                o.present = 1'b1;
                o.slot = s[3:0];
                o.seg_index_out = r.idx;
                o.seg_base = 48'(64'(r.idx) * sb);
                o.seg_size_out = slot_size[s];
                o.length_out = slot_size[s];
            end
            LSCM_REQ_INFO:
            begin
                if (r.offs >= total_cfg)
                    o.status = LSCM_ST_RANGE;
                else
                begin
                    q = 64'(r.offs) / sb;
                    o.seg_index_out = q[LSCM_IDX_W-1:0];
                    o.seg_base = 48'(q * sb);
                    s = lookup_slot(q);
                    if (s >= 0)
                    begin
                        o.present = 1'b1;
                        o.slot = s[3:0];
                        o.seg_size_out = slot_size[s];
                    end
                    else if (q + 1 == seg_count())
                    begin
                        rem = 64'(total_cfg) % sb;
                        o.seg_size_out = (rem == 0) ? sb[LSCM_SEGB_W-1:0]
                                                    : rem[LSCM_SEGB_W-1:0];
                    end
                    else
                        o.seg_size_out = sb[LSCM_SEGB_W-1:0];
                end
            end
            default:
            begin
                o.seg_index_out = r.idx;
                if (64'(r.idx) < seg_count())
                begin
                    s = lookup_slot(r.idx);
                    if (s >= 0)
                    begin
                        o.present = 1'b1;
                        o.slot = s[3:0];
                    end
                end
            end
        endcase
        return o;
    endfunction

    // result checker
    always @(posedge clk)
    begin
        lscm_res_t got;
        lscm_res_t exp_res;
        if (rst_n && rsp.valid && rsp.ready)
        begin
            got = '{rsp.status, rsp.present, rsp.slot, rsp.seg_index_out, rsp.seg_base,
                    rsp.seg_size_out, rsp.offset_in_seg, rsp.length_out, rsp.evicted,
                    rsp.evicted_index};
            if (expected_results.size() == 0)
            begin
                stray_results++;
                $display("[%0t] unexpected result transfer", $realtime);
            end
            else
            begin
                exp_res = expected_results.pop_front();
                results_checked++;
                if (got.evicted)
                    evictions_seen++;
                if (got !== exp_res)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                    begin
                        $display("[%0t] mismatch on result %0d", $realtime, results_checked);
                        $display("  exp st=%0d pr=%0d slot=%0d idx=%0d base=%0h size=%0h",
                                 exp_res.status, exp_res.present, exp_res.slot,
                                 exp_res.seg_index_out, exp_res.seg_base,
                                 exp_res.seg_size_out);
                        $display("      ofs=%0h len=%0h ev=%0d ev_idx=%0d",
                                 exp_res.offset_in_seg, exp_res.length_out,
                                 exp_res.evicted, exp_res.evicted_index);
                        $display("  got st=%0d pr=%0d slot=%0d idx=%0d base=%0h size=%0h",
                                 got.status, got.present, got.slot, got.seg_index_out,
                                 got.seg_base, got.seg_size_out);
                        $display("      ofs=%0h len=%0h ev=%0d ev_idx=%0d",
                                 got.offset_in_seg, got.length_out, got.evicted,
                                 got.evicted_index);
                    end
                end
            end
        end
    end

    // receiver stall pattern
    always @(negedge clk)
    begin
        if (!rst_n)
            rsp.ready <= 1'b0;
        else
        begin
            if (ready_span == 0)
            begin
                case ($urandom_range(0, 3))
                    0: ready_pct = 100;
                    1: ready_pct = 75;
                    2: ready_pct = 40;
                    default: ready_pct = 10;
                endcase
                ready_span = $urandom_range(20, 300);
            end
            else
                ready_span--;
            rsp.ready <= ($urandom_range(0, 99) < ready_pct);
        end
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("Timeout after %0d cycles, %0d results outstanding",
                     cycles, expected_results.size());
            $display("Simulation FAILED");
            $finish;
        end
    end

    task automatic write_register(logic [LSCM_CFGIDX_W-1:0] ri, logic [LSCM_OFF_W-1:0] data);
        @(negedge clk);
        cfg.valid <= 1'b1;
        cfg.index <= ri;
        cfg.data  <= data;
        do
            @(posedge clk);
        while (!cfg.ready);
        case (ri)
            LSCM_CFG_TOTAL: total_cfg = data;
            LSCM_CFG_SEGB:  segb_cfg  = data[LSCM_SEGB_W-1:0];
            LSCM_CFG_SLOTS: slots_cfg = data[LSCM_SLCFG_W-1:0];
            default: ;
        endcase
        cfg_writes++;
        @(negedge clk);
        cfg.valid <= 1'b0;
    endtask

    task automatic wait_drained(bit settle);
        while (expected_results.size() != 0)
            @(posedge clk);
        if (settle)
            repeat (SETTLE) @(posedge clk);
    endtask

    task automatic go_idle();
        @(negedge clk);
        req.valid <= 1'b0;
    endtask

    task automatic set_config(logic [47:0] total, logic [23:0] segb, logic [4:0] slots);
        go_idle();
        wait_drained(1'b1);
        write_register(LSCM_CFG_TOTAL, total);
        write_register(LSCM_CFG_SEGB, 48'(segb));
        write_register(LSCM_CFG_SLOTS, 48'(slots));
    endtask

    task automatic issue_request(request_t r);
        @(negedge clk);
        req.valid          <= 1'b1;
        req.req_type       <= r.kind;
        req.byte_offset_in <= r.offs;
        req.seg_index_in   <= r.idx;
        req.seg_size_in    <= r.size;
        req.read_len       <= r.rlen;
        do
            @(posedge clk);
        while (!req.ready);
        expected_results.push_back(cache_predict(r));
        requests_sent++;
        kind_count[r.kind]++;
    endtask

    // bursty sender: idles between bursts of random length
    task automatic send_paced(request_t r);
        issue_request(r);
        if (burst_left == 0)
        begin
            go_idle();
            repeat ($urandom_range(0, 12)) @(posedge clk);
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 80)
                                                    : $urandom_range(1, 8);
        end
        else
            burst_left--;
    endtask

    function automatic request_t mk(logic [1:0] k, logic [47:0] o, logic [11:0] i,
                                    logic [23:0] sz, logic [23:0] rl);
        return '{k, o, i, sz, rl};
    endfunction

    task automatic test_directed();
        set_config(48'd4194304, 24'd65536, 5'd16);
        send_paced(mk(LSCM_REQ_QUERY, 0, 12'd0, 0, 0));
        send_paced(mk(LSCM_REQ_READ, 48'd70000, 0, 0, 24'd10));
        send_paced(mk(LSCM_REQ_WRITE, 0, 12'd0, 24'd65536, 0));
        send_paced(mk(LSCM_REQ_WRITE, 0, 12'd63, 24'd100, 0));
        send_paced(mk(LSCM_REQ_WRITE, 0, 12'd4095, 24'hFFFFFF, 0));
        send_paced(mk(LSCM_REQ_WRITE, 0, 12'd7, 24'd0, 0));
        send_paced(mk(LSCM_REQ_READ, 48'd63 * 65536 + 200, 0, 0, 24'd50));
        send_paced(mk(LSCM_REQ_READ, 48'd63 * 65536 + 20, 0, 0, 24'hFFFFFF));
        send_paced(mk(LSCM_REQ_READ, 48'd100, 0, 0, 24'd0));
        send_paced(mk(LSCM_REQ_READ, 48'd4095 * 65536 + 48'hFFFF, 0, 0, 24'hFFFFFF));
        send_paced(mk(LSCM_REQ_READ, 48'hFFFF_FFFF_FFFF, 0, 0, 24'hFFFFFF));
        send_paced(mk(LSCM_REQ_WRITE, 0, 12'd63, 24'd999, 0));
        send_paced(mk(LSCM_REQ_INFO, 48'd4194303, 0, 0, 0));
        send_paced(mk(LSCM_REQ_INFO, 48'd4194304, 0, 0, 0));
        send_paced(mk(LSCM_REQ_INFO, 48'hFFFF_FFFF_FFFF, 0, 0, 0));
        send_paced(mk(LSCM_REQ_INFO, 48'd63 * 65536, 0, 0, 0));
        send_paced(mk(LSCM_REQ_INFO, 48'd5 * 65536 + 3, 0, 0, 0));
        send_paced(mk(LSCM_REQ_QUERY, 0, 12'd63, 0, 0));
        send_paced(mk(LSCM_REQ_QUERY, 0, 12'd4095, 0, 0));
        send_paced(mk(LSCM_REQ_QUERY, 0, 12'd64, 0, 0));
    endtask

    // zero segment size, zero slot count, one-byte object
    task automatic test_degenerate_config();
        set_config(48'd1, 24'd0, 5'd0);
        send_paced(mk(LSCM_REQ_WRITE, 0, 12'd5, 24'd3, 0));
        send_paced(mk(LSCM_REQ_WRITE, 0, 12'd6, 24'd1, 0));
        send_paced(mk(LSCM_REQ_READ, 48'd6, 0, 0, 24'd4));
        send_paced(mk(LSCM_REQ_READ, 48'd5, 0, 0, 24'd4));
        send_paced(mk(LSCM_REQ_INFO, 48'd0, 0, 0, 0));
        send_paced(mk(LSCM_REQ_INFO, 48'd1, 0, 0, 0));
        send_paced(mk(LSCM_REQ_QUERY, 0, 12'd0, 0, 0));
        send_paced(mk(LSCM_REQ_QUERY, 0, 12'd6, 0, 0));
    endtask

    // capacity cut below the slots already taken: every new write evicts
    task automatic test_slot_shrink();
        set_config(48'hFFFF_FFFF_FFFF, 24'hFFFFFF, 5'd31);
        for (int i = 0; i < 10; i++)
            send_paced(mk(LSCM_REQ_WRITE, 0, 12'(i * 37), 24'(i * 1000), 0));
        set_config(48'hFFFF_FFFF_FFFF, 24'hFFFFFF, 5'd4);
        for (int i = 0; i < 6; i++)
            send_paced(mk(LSCM_REQ_WRITE, 0, 12'(1000 + i), 24'hABCDE, 0));
        send_paced(mk(LSCM_REQ_QUERY, 0, 12'd37, 0, 0));
    endtask

    task automatic test_random_phase(int n, logic [47:0] total, logic [23:0] segb,
                                     logic [4:0] slots);
        request_t r;
        longint unsigned sb;
        longint unsigned rel;
        int pool_base;
        int pool_len;
        int pick;
        set_config(total, segb, slots);
        sb = eff_segb();
        pool_len = $urandom_range(4, 28);
        pool_base = $urandom_range(0, 4095 - pool_len);
        for (int i = 0; i < n; i++)
        begin
            r.idx  = 12'(pool_base + $urandom_range(0, pool_len - 1));
            rel    = ($urandom_range(0, 3) == 0) ? 64'($urandom) % (sb + 2)
                                                 : 64'($urandom) % sb;
            r.offs = 48'(64'(r.idx) * sb + rel);
            r.size = ($urandom_range(0, 1) == 0) ? 24'($urandom) : sb[23:0];
            r.rlen = ($urandom_range(0, 1) == 0) ? 24'($urandom)
                                                 : 24'($urandom_range(0, 300));
            pick = $urandom_range(0, 99);
            if (pick < 30)
                r.kind = LSCM_REQ_WRITE;
            else if (pick < 65)
                r.kind = LSCM_REQ_READ;
            else if (pick < 80)
                r.kind = LSCM_REQ_INFO;
            else if (pick < 94)
                r.kind = LSCM_REQ_QUERY;
            else
            begin
                r.kind = 2'($urandom);
                r.offs = {16'($urandom), 32'($urandom)};
                r.idx  = 12'($urandom);
            end
            send_paced(r);
            if ($urandom_range(0, 199) == 0)
            begin
                go_idle();
                wait_drained(1'b0);
            end
        end
    endtask

    initial
    begin
        req.valid = 1'b0;
        req.req_type = LSCM_REQ_READ;
        req.byte_offset_in = '0;
        req.seg_index_in = '0;
        req.seg_size_in = '0;
        req.read_len = '0;
        rsp.ready = 1'b0;
        cfg.valid = 1'b0;
        cfg.index = LSCM_CFG_TOTAL;
        cfg.data = '0;
        total_cfg = LSCM_TOTAL_RST;
        segb_cfg = LSCM_SEGB_RST;
        slots_cfg = LSCM_SLCFG_RST;
        taken = 0;
        foreach (seg_cached[i])
            seg_cached[i] = 1'b0;
        rst_n = 1'b0;
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_directed();
        test_degenerate_config();
        test_slot_shrink();
        test_random_phase(300, 48'd4194304, 24'd65536, 5'd16);
        test_random_phase(300, 48'hFFFF_FFFF_FFFF, 24'hFFFFFF, 5'd31);
        test_random_phase(250, 48'd1000, 24'd0, 5'd0);
        test_random_phase(300, {16'($urandom), 32'($urandom)}, 24'($urandom),
                          5'($urandom_range(1, 16)));
        test_random_phase(300, 48'($urandom_range(1, 5000000)), 24'($urandom_range(1, 70000)),
                          5'($urandom_range(2, 8)));
        test_random_phase(320, 48'd123456789, 24'd30011, 5'd3);

        go_idle();
        wait_drained(1'b1);
        $display("Covered %0d requests (rd %0d wr %0d info %0d query %0d), %0d config writes",
                 requests_sent, kind_count[LSCM_REQ_READ], kind_count[LSCM_REQ_WRITE],
                 kind_count[LSCM_REQ_INFO], kind_count[LSCM_REQ_QUERY], cfg_writes);
        $display("Checked %0d results, %0d with eviction; %0d mismatches, %0d stray",
                 results_checked, evictions_seen, mismatches, stray_results);
        if (mismatches == 0 && stray_results == 0 && expected_results.size() == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end
endmodule
`default_nettype wire

[sim.f]
+incdir+hw/rtl
hw/rtl/lscm_pkg.sv
hw/rtl/lscm_if.sv
hw/rtl/lscm_div.sv
hw/rtl/lscm_dp.sv
hw/rtl/lscm_ctrl.sv
hw/rtl/lru_segment_cache_manager.sv
bench/tb_top.sv
